// File: hw/rtl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned PROD_W  = 2 * ELEM_W;
    localparam int unsigned ACC_W   = PROD_W + 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned STEP_W  = 6;

    localparam logic [ADDR_W-1:0] LAST_SLOT = 4'd15;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
    localparam logic [IDX_W-1:0]  LAST_IDX  = 2'd3;
    localparam logic [IDX_W-1:0]  FIRST_IDX = 2'd0;

    typedef enum logic [0:0] {
        SEQ_LOAD,
        SEQ_CALC
    } seq_state_t;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

endpackage

// File: hw/rtl/mm4_bank.sv
// Element stores for both matrices: one write port, one registered read port each.
module mm4_bank (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [mm4_pkg::ADDR_W-1:0]             wr_addr,
    input  logic signed [mm4_pkg::ELEM_W-1:0]      wr_left,
    input  logic signed [mm4_pkg::ELEM_W-1:0]      wr_right,
    input  logic                                   rd_en,
    input  logic [mm4_pkg::ADDR_W-1:0]             rd_addr_left,
    input  logic [mm4_pkg::ADDR_W-1:0]             rd_addr_right,
    output logic signed [mm4_pkg::ELEM_W-1:0]      rd_left,
    output logic signed [mm4_pkg::ELEM_W-1:0]      rd_right
);
    import mm4_pkg::*;

    logic signed [ELEM_W-1:0] left_mem  [16];
    logic signed [ELEM_W-1:0] right_mem [16];
    logic signed [ELEM_W-1:0] rd_left_reg;
    logic signed [ELEM_W-1:0] rd_right_reg;

    // Store incoming elements
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
    end

    // Read operands, hold while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_left_reg  <= left_mem[rd_addr_left];
            rd_right_reg <= right_mem[rd_addr_right];
        end
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

// File: hw/rtl/mm4_seq.sv
// Sequencer: counts loaded items, then steps through the 64 multiply-accumulates.
module mm4_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          adv,
    output logic                          s_ready,
    output logic                          wr_en,
    output logic [mm4_pkg::ADDR_W-1:0]    wr_addr,
    output logic [mm4_pkg::ADDR_W-1:0]    rd_addr_left,
    output logic [mm4_pkg::ADDR_W-1:0]    rd_addr_right,
    output mm4_pkg::mac_tag_t             issue_tag
);
    import mm4_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] load_count_reg, load_count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;
    logic [IDX_W-1:0]  row, col, k;

    assign accept = s_valid && s_ready;
    assign row    = step_reg[5:4];
    assign col    = step_reg[3:2];
    assign k      = step_reg[1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_LOAD: begin
                if (accept && load_count_reg == LAST_SLOT) begin
                    state_next = SEQ_CALC;
                end
            end
            SEQ_CALC: begin
                if (adv && step_reg == LAST_STEP) begin
                    state_next = SEQ_LOAD;
                end
            end
            default: state_next = SEQ_LOAD;
        endcase
    end

    // Counters
    always_comb begin
        load_count_next = load_count_reg;
        step_next       = step_reg;
        if (accept) begin
            load_count_next = load_count_reg + 1'b1;
        end
        if (state_reg == SEQ_CALC && adv) begin
            step_next = step_reg + 1'b1;
        end
    end

    // Outputs
    always_comb begin
        s_ready         = (state_reg == SEQ_LOAD);
        wr_en           = accept;
        wr_addr         = load_count_reg;
        rd_addr_left    = {row, k};
        rd_addr_right   = {k, col};
        issue_tag.valid = (state_reg == SEQ_CALC);
        issue_tag.first = (k == FIRST_IDX);
        issue_tag.last  = (k == LAST_IDX);
        issue_tag.row   = row;
        issue_tag.col   = col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_LOAD;
            load_count_reg <= '0;
            step_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            step_reg       <= step_next;
        end
    end

endmodule

// File: hw/rtl/mm4_mac.sv
// Shared multiply-accumulate pipeline with floor shift, saturation and output register.
module mm4_mac #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  mm4_pkg::mac_tag_t                   issue_tag,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   op_left,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   op_right,
    output logic                                m_valid,
    output logic signed [mm4_pkg::ELEM_W-1:0]   m_product_element,
    output logic [mm4_pkg::IDX_W-1:0]           m_row_index,
    output logic [mm4_pkg::IDX_W-1:0]           m_column_index,
    output logic                                m_final_flag
);
    import mm4_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh0000_0000_8000_0000);

    mac_tag_t                 tag1_reg, tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  prod_ext, shifted;
    logic                     done_reg;
    logic [IDX_W-1:0]         done_row_reg, done_col_reg;
    logic                     out_valid_reg;
    logic signed [ELEM_W-1:0] out_data_reg, sat_value;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                     out_final_reg;

    // Align tags with operand read and product stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else if (adv) begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
        end
    end

    // Multiply
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= op_left * op_right;
        end
    end

    // Accumulate at full width
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    always_comb begin
        acc_next = acc_reg;
        if (tag2_reg.valid) begin
            acc_next = tag2_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg      <= acc_next;
            done_row_reg <= tag2_reg.row;
            done_col_reg <= tag2_reg.col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (adv) begin
            done_reg <= tag2_reg.valid && tag2_reg.last;
        end
    end

    // Floor shift and saturate
    assign shifted = acc_reg >>> FRAC_BITS;
    always_comb begin
        if (shifted > SAT_MAX) begin
            sat_value = SAT_MAX[ELEM_W-1:0];
        end else if (shifted < SAT_MIN) begin
            sat_value = SAT_MIN[ELEM_W-1:0];
        end else begin
            sat_value = shifted[ELEM_W-1:0];
        end
    end

    // Output register: load when a finished element arrives, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && done_reg) begin
            out_data_reg  <= sat_value;
            out_row_reg   <= done_row_reg;
            out_col_reg   <= done_col_reg;
            out_final_reg <= (done_row_reg == LAST_IDX) && (done_col_reg == LAST_IDX);
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_product_element = out_data_reg;
    assign m_row_index       = out_row_reg;
    assign m_column_index    = out_col_reg;
    assign m_final_flag      = out_final_reg;

endmodule

// File: hw/rtl/matrix_multiply_4x4.sv
// The 16th item of a pair starts the 64 MACs; each element then passes the operand
// read, product, accumulate and output registers. Throughput: one MAC per cycle
// unless stalled, four MACs per element, set by the single shared multiplier.
// The result side stalls the whole MAC pipeline while an element waits to be taken.
// Reset (aresetn low, synchronous) clears the load count, sequencer and valid flags;
// the element stores are not cleared.
module matrix_multiply_4x4 #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   s_left_element,
    input  logic signed [mm4_pkg::ELEM_W-1:0]   s_right_element,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mm4_pkg::ELEM_W-1:0]   m_product_element,
    output logic [mm4_pkg::IDX_W-1:0]           m_row_index,
    output logic [mm4_pkg::IDX_W-1:0]           m_column_index,
    output logic                                m_final_flag
);
    import mm4_pkg::*;

    logic                     adv;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr_left, rd_addr_right;
    logic signed [ELEM_W-1:0] op_left, op_right;
    mac_tag_t                 issue_tag;

    // Advance the pipeline unless a result is waiting and not taken
    assign adv = !m_valid || m_ready;

    mm4_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .adv           (adv),
        .s_ready       (s_ready),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_addr_left  (rd_addr_left),
        .rd_addr_right (rd_addr_right),
        .issue_tag     (issue_tag)
    );

    mm4_bank u_bank (
        .aclk          (aclk),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_left       (s_left_element),
        .wr_right      (s_right_element),
        .rd_en         (adv),
        .rd_addr_left  (rd_addr_left),
        .rd_addr_right (rd_addr_right),
        .rd_left       (op_left),
        .rd_right      (op_right)
    );

    mm4_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .adv               (adv),
        .issue_tag         (issue_tag),
        .op_left           (op_left),
        .op_right          (op_right),
        .m_valid           (m_valid),
        .m_product_element (m_product_element),
        .m_row_index       (m_row_index),
        .m_column_index    (m_column_index),
        .m_final_flag      (m_final_flag)
    );

endmodule

// File: hw/rtl/mm4_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
module mm4_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [mm4_pkg::ELEM_W-1:0]   m_product_element,
    input logic [mm4_pkg::IDX_W-1:0]           m_row_index,
    input logic [mm4_pkg::IDX_W-1:0]           m_column_index,
    input logic                                m_final_flag
);
    import mm4_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product_element)
            && $stable(m_row_index) && $stable(m_column_index))
        else $error("stalled result changed");

    // An offered item stays offered until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item withdrawn before accept");

    // Final flag only on the last element
    a_final_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_flag |-> m_row_index == LAST_IDX && m_column_index == LAST_IDX)
        else $error("final flag on wrong element");

    // Last element always flagged
    a_final_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_index == LAST_IDX && m_column_index == LAST_IDX |-> m_final_flag)
        else $error("last element not flagged");

    // No results come out right after reset, and the input is open
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("wrong handshake state after reset");

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_product_element (m_product_element),
    .m_row_index       (m_row_index),
    .m_column_index    (m_column_index),
    .m_final_flag      (m_final_flag)
);
